>>> rtl/swept_box_slab_intersect_top_macros.svh
// Assertion macros for the swept box slab intersection block.
`ifndef SWEPT_BOX_SLAB_INTERSECT_TOP_MACROS_SVH
`define SWEPT_BOX_SLAB_INTERSECT_TOP_MACROS_SVH
`ifndef SYNTH
`define SBSI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbsi assertion failed");
`define SBSI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbsi assertion failed");
`else
`define SBSI_ASSERT_IMP(lbl, ante, cons)
`define SBSI_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/sbsi_pkg.sv
`default_nettype none
package sbsi_pkg;
    localparam int TIME_FRAC_BITS = 16;
    localparam int CW = 36;
    localparam int NUM_W = 34;
    localparam int DEN_W = 33;
    localparam int QW = NUM_W + TIME_FRAC_BITS;
    localparam int TW = QW + 2;
    localparam int HT_W = 17;
    localparam int PW = TIME_FRAC_BITS + 34;
    localparam int SW = 34;

    localparam logic signed [TW-1:0] T_MAX = {1'b0, {(TW-1){1'b1}}};
    localparam logic signed [TW-1:0] T_MIN = {1'b1, {(TW-1){1'b0}}};
    localparam logic signed [TW-1:0] T_ONE = TW'(64'd1 << TIME_FRAC_BITS);

    localparam logic signed [1:0] NRM_POS = 2'sb01;
    localparam logic signed [1:0] NRM_NEG = 2'sb11;
    localparam logic signed [1:0] NRM_ZERO = 2'sb00;

    typedef struct packed {
        logic               ok;
        logic [1:0]         zero;
        logic [1:0]         neg_n;
        logic [1:0]         neg_f;
        logic signed [31:0] d_x;
        logic signed [31:0] d_y;
        logic signed [31:0] mc_x;
        logic signed [31:0] mc_y;
    } side_t;
endpackage
`default_nettype wire

>>> rtl/sbsi_div.sv
`default_nettype none
module sbsi_div (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [sbsi_pkg::NUM_W-1:0]  num,
    input  wire logic [sbsi_pkg::DEN_W-1:0]  den,
    output logic      [sbsi_pkg::QW-1:0]     quo,
    output logic                             rem_nz
);
    import sbsi_pkg::*;

    logic [DEN_W-1:0] rem_reg [QW];
    logic [QW-1:0]    quo_reg [QW];
    logic [NUM_W-1:0] num_reg [QW-1];
    logic [DEN_W-1:0] den_reg [QW-1];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        localparam int BI = QW - 1 - k;
        logic [DEN_W-1:0] rem_in;
        logic [QW-1:0]    quo_in;
        logic [NUM_W-1:0] num_in;
        logic [DEN_W-1:0] den_in;
        logic             dbit;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;
        logic [DEN_W-1:0] rem_next;
        logic [QW-1:0]    quo_next;

        if (k == 0)
        begin : g_first
            assign rem_in = '0;
            assign quo_in = '0;
            assign num_in = num;
            assign den_in = den;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign num_in = num_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        if (BI >= TIME_FRAC_BITS)
        begin : g_bit
            assign dbit = num_in[BI-TIME_FRAC_BITS];
        end
        else
        begin : g_zero
            assign dbit = 1'b0;
        end

        assign trial = {rem_in, dbit};
        assign diff = trial - {1'b0, den_in};
        assign ge = trial >= {1'b0, den_in};
        assign rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

        always_comb
        begin
            quo_next = quo_in;
            quo_next[BI] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                quo_reg[k] <= quo_next;
            end
        end

        if (k < QW - 1)
        begin : g_pass
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[k] <= num_in;
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[QW-1];
    assign rem_nz = |rem_reg[QW-1];
endmodule
`default_nettype wire

>>> rtl/swept_box_slab_intersect_top.sv
// Throughput: one request per cycle while the result is not stalled; the four slab
// divisions are pipelined restoring dividers that retire one quotient bit per stage.
// A stalled result freezes the whole pipeline; no request is lost or repeated.
// Reset is asynchronous and active low and clears only the valid bits.
`default_nettype none
`include "swept_box_slab_intersect_top_macros.svh"
module swept_box_slab_intersect_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [31:0]                   fixed_center_x,
    input  wire logic signed [31:0]                   fixed_center_y,
    input  wire logic [30:0]                          fixed_width,
    input  wire logic [30:0]                          fixed_height,
    input  wire logic signed [31:0]                   moving_center_x,
    input  wire logic signed [31:0]                   moving_center_y,
    input  wire logic [30:0]                          moving_width,
    input  wire logic [30:0]                          moving_height,
    input  wire logic signed [31:0]                   motion_x,
    input  wire logic signed [31:0]                   motion_y,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      hit,
    output logic [sbsi_pkg::HT_W-1:0]                 hit_time,
    output logic signed [31:0]                        contact_x,
    output logic signed [31:0]                        contact_y,
    output logic signed [1:0]                         normal_x,
    output logic signed [1:0]                         normal_y
);
    import sbsi_pkg::*;

    logic adv;

    logic signed [31:0] fc [2];
    logic [30:0]        fs [2];
    logic signed [31:0] mc [2];
    logic [30:0]        ms [2];
    logic signed [31:0] dv [2];

    logic signed [CW-1:0] c2_a [2];
    logic signed [CW-1:0] sp_a [2];
    logic signed [CW-1:0] sm_a [2];
    logic signed [CW-1:0] a2_a [2];
    logic [1:0]           ins_a;

    logic                 v1_reg;
    logic                 ins_s1_reg;
    logic signed [CW-1:0] c2_s1_reg [2];
    logic signed [CW-1:0] sp_s1_reg [2];
    logic signed [CW-1:0] sm_s1_reg [2];
    logic signed [CW-1:0] a2_s1_reg [2];
    logic signed [31:0]   d_s1_reg [2];
    logic signed [31:0]   mc_s1_reg [2];

    logic signed [CW-1:0] s_b [2];

    logic                 v2_reg;
    logic signed [CW-1:0] lo_s2_reg [2];
    logic signed [CW-1:0] hi_s2_reg [2];
    logic signed [CW-1:0] a2_s2_reg [2];
    logic signed [31:0]   d_s2_reg [2];
    logic signed [31:0]   mc_s2_reg [2];

    logic [1:0]           zero_c;
    logic [1:0]           ok_c;
    logic signed [CW-1:0] nn_c [2];
    logic signed [CW-1:0] nf_c [2];
    logic [31:0]          dabs_c [2];

    logic                 v3_reg;
    logic signed [CW-1:0] nn_s3_reg [2];
    logic signed [CW-1:0] nf_s3_reg [2];
    logic [DEN_W-1:0]     den_s3_reg [2];
    logic [1:0]           zero_s3_reg;
    logic [1:0]           ok_s3_reg;
    logic signed [31:0]   d_s3_reg [2];
    logic signed [31:0]   mc_s3_reg [2];

    logic signed [CW-1:0] nn_abs [2];
    logic signed [CW-1:0] nf_abs [2];

    logic                 v4_reg;
    logic [NUM_W-1:0]     nmag_s4_reg [2];
    logic [NUM_W-1:0]     fmag_s4_reg [2];
    logic [DEN_W-1:0]     den_s4_reg [2];
    side_t                side_s4_reg;
    side_t                side_next;

    logic                 vdiv_reg [QW];
    side_t                side_reg [QW];

    logic [QW-1:0]        qn [2];
    logic [QW-1:0]        qf [2];
    logic [1:0]           rn_nz;
    logic [1:0]           rf_nz;

    logic signed [TW-1:0] en_e [2];
    logic signed [TW-1:0] ex_e [2];

    logic                 e0_valid_reg;
    logic signed [TW-1:0] en_e0_reg [2];
    logic signed [TW-1:0] ex_e0_reg [2];
    side_t                side_e0_reg;

    logic                 e1_valid_reg;
    logic                 miss_e1_reg;
    logic                 xent_e1_reg;
    logic                 xext_e1_reg;
    logic signed [TW-1:0] ent_e1_reg;
    logic signed [TW-1:0] ext_e1_reg;
    side_t                side_e1_reg;

    logic                 ent_in;
    logic                 ext_in;
    logic                 use_x;
    logic signed [TW-1:0] t_sel;

    logic                        e2_valid_reg;
    logic                        hit_e2_reg;
    logic [TIME_FRAC_BITS:0]     t_e2_reg;
    logic signed [1:0]           nx_e2_reg;
    logic signed [1:0]           ny_e2_reg;
    logic signed [31:0]          d_e2_reg [2];
    logic signed [31:0]          mc_e2_reg [2];

    logic                        m_valid_reg;
    logic                        hit_m_reg;
    logic [TIME_FRAC_BITS:0]     t_m_reg;
    logic signed [1:0]           nx_m_reg;
    logic signed [1:0]           ny_m_reg;
    logic signed [PW-1:0]        prod_m_reg [2];
    logic signed [31:0]          mc_m_reg [2];

    logic signed [SW-1:0]        sum_c [2];
    logic signed [31:0]          sat_c [2];

    logic                        out_valid_reg;
    logic                        hit_reg;
    logic [HT_W-1:0]             hit_time_reg;
    logic signed [31:0]          contact_reg [2];
    logic signed [1:0]           normal_x_reg;
    logic signed [1:0]           normal_y_reg;

    assign adv = !(out_valid_reg && out_stall);
    assign in_stall = out_valid_reg && out_stall;

    assign fc[0] = fixed_center_x;
    assign fc[1] = fixed_center_y;
    assign fs[0] = fixed_width;
    assign fs[1] = fixed_height;
    assign mc[0] = moving_center_x;
    assign mc[1] = moving_center_y;
    assign ms[0] = moving_width;
    assign ms[1] = moving_height;
    assign dv[0] = motion_x;
    assign dv[1] = motion_y;

    // Stage 1: doubled bounds of the outward padded box and the inside test.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            c2_a[i] = CW'(fc[i]) <<< 1;
            sp_a[i] = CW'(fs[i]) + CW'(ms[i]);
            sm_a[i] = CW'(fs[i]) - CW'(ms[i]);
            a2_a[i] = CW'(mc[i]) <<< 1;
            ins_a[i] = (c2_a[i] - sp_a[i] < a2_a[i]) && (a2_a[i] < c2_a[i] + sp_a[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ins_s1_reg <= &ins_a;
            for (int i = 0; i < 2; i++)
            begin
                c2_s1_reg[i] <= c2_a[i];
                sp_s1_reg[i] <= sp_a[i];
                sm_s1_reg[i] <= sm_a[i];
                a2_s1_reg[i] <= a2_a[i];
                d_s1_reg[i] <= dv[i];
                mc_s1_reg[i] <= mc[i];
            end
        end
    end

    // Stage 2: slab bounds; an inward padded box may have crossed bounds.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            s_b[i] = ins_s1_reg ? sm_s1_reg[i] : sp_s1_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 2; i++)
            begin
                lo_s2_reg[i] <= c2_s1_reg[i] - s_b[i];
                hi_s2_reg[i] <= c2_s1_reg[i] + s_b[i];
                a2_s2_reg[i] <= a2_s1_reg[i];
                d_s2_reg[i] <= d_s1_reg[i];
                mc_s2_reg[i] <= mc_s1_reg[i];
            end
        end
    end

    // Stage 3: numerators oriented so that the denominator is positive.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            zero_c[i] = d_s2_reg[i] == 32'sd0;
            ok_c[i] = !zero_c[i] ||
                      ((lo_s2_reg[i] < a2_s2_reg[i]) && (a2_s2_reg[i] < hi_s2_reg[i]));
            if (d_s2_reg[i] > 32'sd0)
            begin
                nn_c[i] = lo_s2_reg[i] - a2_s2_reg[i];
                nf_c[i] = hi_s2_reg[i] - a2_s2_reg[i];
            end
            else
            begin
                nn_c[i] = a2_s2_reg[i] - hi_s2_reg[i];
                nf_c[i] = a2_s2_reg[i] - lo_s2_reg[i];
            end
            dabs_c[i] = d_s2_reg[i][31] ? (32'd0 - d_s2_reg[i]) : d_s2_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zero_s3_reg <= zero_c;
            ok_s3_reg <= ok_c;
            for (int i = 0; i < 2; i++)
            begin
                nn_s3_reg[i] <= nn_c[i];
                nf_s3_reg[i] <= nf_c[i];
                den_s3_reg[i] <= {dabs_c[i], 1'b0};
                d_s3_reg[i] <= d_s2_reg[i];
                mc_s3_reg[i] <= mc_s2_reg[i];
            end
        end
    end

    // Stage 4: magnitudes for the unsigned dividers.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            nn_abs[i] = nn_s3_reg[i][CW-1] ? -nn_s3_reg[i] : nn_s3_reg[i];
            nf_abs[i] = nf_s3_reg[i][CW-1] ? -nf_s3_reg[i] : nf_s3_reg[i];
        end
        side_next.ok = &ok_s3_reg;
        side_next.zero = zero_s3_reg;
        side_next.neg_n = {nn_s3_reg[1][CW-1], nn_s3_reg[0][CW-1]};
        side_next.neg_f = {nf_s3_reg[1][CW-1], nf_s3_reg[0][CW-1]};
        side_next.d_x = d_s3_reg[0];
        side_next.d_y = d_s3_reg[1];
        side_next.mc_x = mc_s3_reg[0];
        side_next.mc_y = mc_s3_reg[1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_s4_reg <= side_next;
            for (int i = 0; i < 2; i++)
            begin
                nmag_s4_reg[i] <= nn_abs[i][NUM_W-1:0];
                fmag_s4_reg[i] <= nf_abs[i][NUM_W-1:0];
                den_s4_reg[i] <= den_s3_reg[i];
            end
        end
    end

    for (genvar a = 0; a < 2; a++)
    begin : g_axis
        sbsi_div u_div_near (
            .clk    (clk),
            .en     (adv),
            .num    (nmag_s4_reg[a]),
            .den    (den_s4_reg[a]),
            .quo    (qn[a]),
            .rem_nz (rn_nz[a])
        );
        sbsi_div u_div_far (
            .clk    (clk),
            .en     (adv),
            .num    (fmag_s4_reg[a]),
            .den    (den_s4_reg[a]),
            .quo    (qf[a]),
            .rem_nz (rf_nz[a])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_s4_reg;
            for (int k = 1; k < QW; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Floor division: a negative quotient with a remainder steps down by one.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            if (side_reg[QW-1].zero[i])
            begin
                en_e[i] = T_MIN;
                ex_e[i] = T_MAX;
            end
            else
            begin
                en_e[i] = side_reg[QW-1].neg_n[i] ?
                          -(TW'(qn[i]) + TW'(rn_nz[i])) : TW'(qn[i]);
                ex_e[i] = side_reg[QW-1].neg_f[i] ?
                          -(TW'(qf[i]) + TW'(rf_nz[i])) : TW'(qf[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_e0_reg <= side_reg[QW-1];
            for (int i = 0; i < 2; i++)
            begin
                en_e0_reg[i] <= en_e[i];
                ex_e0_reg[i] <= ex_e[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_e1_reg <= side_e0_reg;
            miss_e1_reg <= !side_e0_reg.ok || (ex_e0_reg[0] < en_e0_reg[1]) ||
                           (ex_e0_reg[1] < en_e0_reg[0]);
            xent_e1_reg <= en_e0_reg[0] > en_e0_reg[1];
            xext_e1_reg <= ex_e0_reg[0] < ex_e0_reg[1];
            ent_e1_reg <= (en_e0_reg[0] > en_e0_reg[1]) ? en_e0_reg[0] : en_e0_reg[1];
            ext_e1_reg <= (ex_e0_reg[0] < ex_e0_reg[1]) ? ex_e0_reg[0] : ex_e0_reg[1];
        end
    end

    // Entry time wins when it lies in the step, otherwise the exit time.
    assign ent_in = (ent_e1_reg >= 0) && (ent_e1_reg <= T_ONE);
    assign ext_in = (ext_e1_reg > 0) && (ext_e1_reg <= T_ONE);
    assign use_x = ent_in ? xent_e1_reg : xext_e1_reg;
    assign t_sel = ent_in ? ent_e1_reg : ext_e1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_e2_reg <= !miss_e1_reg && (ent_in || ext_in);
            t_e2_reg <= t_sel[TIME_FRAC_BITS:0];
            nx_e2_reg <= !use_x ? NRM_ZERO : ((side_e1_reg.d_x > 0) ? NRM_NEG : NRM_POS);
            ny_e2_reg <= use_x ? NRM_ZERO : ((side_e1_reg.d_y > 0) ? NRM_NEG : NRM_POS);
            d_e2_reg[0] <= side_e1_reg.d_x;
            d_e2_reg[1] <= side_e1_reg.d_y;
            mc_e2_reg[0] <= side_e1_reg.mc_x;
            mc_e2_reg[1] <= side_e1_reg.mc_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_m_reg <= hit_e2_reg;
            t_m_reg <= t_e2_reg;
            nx_m_reg <= nx_e2_reg;
            ny_m_reg <= ny_e2_reg;
            for (int i = 0; i < 2; i++)
            begin
                prod_m_reg[i] <= PW'($signed({1'b0, t_e2_reg}) * d_e2_reg[i]);
                mc_m_reg[i] <= mc_e2_reg[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            sum_c[i] = SW'(mc_m_reg[i]) + SW'(prod_m_reg[i] >>> TIME_FRAC_BITS);
            if (sum_c[i] > SW'(32'sh7FFF_FFFF))
            begin
                sat_c[i] = 32'sh7FFF_FFFF;
            end
            else if (sum_c[i] < -SW'(64'sh8000_0000))
            begin
                sat_c[i] = 32'sh8000_0000;
            end
            else
            begin
                sat_c[i] = sum_c[i][31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg <= hit_m_reg;
            if (hit_m_reg)
            begin
                hit_time_reg <= HT_W'(t_m_reg);
                contact_reg[0] <= sat_c[0];
                contact_reg[1] <= sat_c[1];
                normal_x_reg <= nx_m_reg;
                normal_y_reg <= ny_m_reg;
            end
            else
            begin
                hit_time_reg <= HT_W'(T_ONE);
                contact_reg[0] <= '0;
                contact_reg[1] <= '0;
                normal_x_reg <= NRM_ZERO;
                normal_y_reg <= NRM_ZERO;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            for (int k = 0; k < QW; k++)
            begin
                vdiv_reg[k] <= 1'b0;
            end
            e0_valid_reg <= 1'b0;
            e1_valid_reg <= 1'b0;
            e2_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            vdiv_reg[0] <= v4_reg;
            for (int k = 1; k < QW; k++)
            begin
                vdiv_reg[k] <= vdiv_reg[k-1];
            end
            e0_valid_reg <= vdiv_reg[QW-1];
            e1_valid_reg <= e0_valid_reg;
            e2_valid_reg <= e1_valid_reg;
            m_valid_reg <= e2_valid_reg;
            out_valid_reg <= m_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit = hit_reg;
    assign hit_time = hit_time_reg;
    assign contact_x = contact_reg[0];
    assign contact_y = contact_reg[1];
    assign normal_x = normal_x_reg;
    assign normal_y = normal_y_reg;

    `SBSI_ASSERT_IMP(a_miss_zero, out_valid_reg && !hit_reg, (hit_time_reg == HT_W'(T_ONE)) && (contact_reg[0] == 0) && (contact_reg[1] == 0) && (normal_x_reg == NRM_ZERO) && (normal_y_reg == NRM_ZERO))
    `SBSI_ASSERT_IMP(a_hit_one_normal, out_valid_reg && hit_reg, (normal_x_reg != NRM_ZERO) != (normal_y_reg != NRM_ZERO))
    `SBSI_ASSERT_IMP(a_hit_time_range, e2_valid_reg && hit_e2_reg, !t_e2_reg[TIME_FRAC_BITS] || (t_e2_reg[TIME_FRAC_BITS-1:0] == 0))
    `SBSI_ASSERT_NXT(a_div_valid_moves, vdiv_reg[QW-1] && adv, e0_valid_reg)
endmodule
`default_nettype wire

>>> tb/sv/swept_box_slab_intersect_checker.sv
`default_nettype none
module swept_box_slab_intersect_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic signed [31:0] fixed_center_x,
    input  wire logic signed [31:0] fixed_center_y,
    input  wire logic [30:0]        fixed_width,
    input  wire logic [30:0]        fixed_height,
    input  wire logic signed [31:0] moving_center_x,
    input  wire logic signed [31:0] moving_center_y,
    input  wire logic [30:0]        moving_width,
    input  wire logic [30:0]        moving_height,
    input  wire logic signed [31:0] motion_x,
    input  wire logic signed [31:0] motion_y,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic               hit,
    input  wire logic [16:0]        hit_time,
    input  wire logic signed [31:0] contact_x,
    input  wire logic signed [31:0] contact_y,
    input  wire logic signed [1:0]  normal_x,
    input  wire logic signed [1:0]  normal_y,
    output int                      errors,
    output int                      pending,
    output int                      hits_seen
);
    import sbsi_pkg::*;

    localparam longint TIME_ONE = 64'sd1 << TIME_FRAC_BITS;
    localparam longint TIME_LOW = 64'sh8000000000000000;
    localparam longint TIME_HIGH = 64'sh7fffffffffffffff;

    typedef struct packed {
        logic               hit;
        logic [16:0]        hit_time;
        logic signed [31:0] contact_x;
        logic signed [31:0] contact_y;
        logic signed [1:0]  normal_x;
        logic signed [1:0]  normal_y;
    } sweep_result_t;

    sweep_result_t expected_sweeps[$];

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q--;
        return q;
    endfunction

    function automatic bit slab_times(input longint c2, input longint sz, input longint a2,
                                      input longint d, output longint t_in,
                                      output longint t_out);
        longint lo, hi, near, far, den;
        lo = c2 - sz;
        hi = c2 + sz;
        t_in = 0;
        t_out = 0;
        if (d == 0)
        begin
            if (!(lo < a2 && a2 < hi))
                return 0;
            t_in = TIME_LOW;
            t_out = TIME_HIGH;
            return 1;
        end
        near = ((d > 0) ? lo : hi) - a2;
        far = ((d > 0) ? hi : lo) - a2;
        den = 2 * d;
        if (den < 0)
        begin
            den = -den;
            near = -near;
            far = -far;
        end
        t_in = floor_div(near * TIME_ONE, den);
        t_out = floor_div(far * TIME_ONE, den);
        return 1;
    endfunction

    function automatic logic signed [31:0] contact_at(longint a, longint d, longint t);
        longint v;
        v = a + floor_div(t * d, TIME_ONE);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic sweep_result_t predict_sweep();
        sweep_result_t r;
        longint fc[2], fs[2], mc[2], ms[2], dv[2], t_in[2], t_out[2];
        longint s, t_enter, t_exit, t;
        bit padded_in, ok, found;
        logic signed [1:0] nx, ny;
        fc[0] = longint'(fixed_center_x);
        fc[1] = longint'(fixed_center_y);
        fs[0] = longint'(fixed_width);
        fs[1] = longint'(fixed_height);
        mc[0] = longint'(moving_center_x);
        mc[1] = longint'(moving_center_y);
        ms[0] = longint'(moving_width);
        ms[1] = longint'(moving_height);
        dv[0] = longint'(motion_x);
        dv[1] = longint'(motion_y);
        padded_in = 1;
        ok = 1;
        found = 0;
        t = 0;
        nx = NRM_ZERO;
        ny = NRM_ZERO;
        for (int i = 0; i < 2; i++)
        begin
            s = fs[i] + ms[i];
            if (!(2 * fc[i] - s < 2 * mc[i] && 2 * mc[i] < 2 * fc[i] + s))
                padded_in = 0;
        end
        for (int i = 0; i < 2; i++)
        begin
            s = padded_in ? fs[i] - ms[i] : fs[i] + ms[i];
            if (!slab_times(2 * fc[i], s, 2 * mc[i], dv[i], t_in[i], t_out[i]))
                ok = 0;
        end
        if (ok && !(t_out[0] < t_in[1] || t_out[1] < t_in[0]))
        begin
            t_enter = t_in[0] > t_in[1] ? t_in[0] : t_in[1];
            t_exit = t_out[0] < t_out[1] ? t_out[0] : t_out[1];
            if (t_enter >= 0 && t_enter <= TIME_ONE)
            begin
                found = 1;
                t = t_enter;
                if (t_in[0] > t_in[1])
                    nx = dv[0] > 0 ? NRM_NEG : NRM_POS;
                else
                    ny = dv[1] > 0 ? NRM_NEG : NRM_POS;
            end
            else if (t_exit > 0 && t_exit <= TIME_ONE)
            begin
                found = 1;
                t = t_exit;
                if (t_out[0] < t_out[1])
                    nx = dv[0] > 0 ? NRM_NEG : NRM_POS;
                else
                    ny = dv[1] > 0 ? NRM_NEG : NRM_POS;
            end
        end
        r.hit = found;
        if (found)
        begin
            r.hit_time = t[16:0];
            r.contact_x = contact_at(mc[0], dv[0], t);
            r.contact_y = contact_at(mc[1], dv[1], t);
            r.normal_x = nx;
            r.normal_y = ny;
        end
        else
        begin
            r.hit_time = TIME_ONE[16:0];
            r.contact_x = '0;
            r.contact_y = '0;
            r.normal_x = NRM_ZERO;
            r.normal_y = NRM_ZERO;
        end
        return r;
    endfunction

    initial
    begin
        errors = 0;
        pending = 0;
        hits_seen = 0;
    end

    always @(posedge clk)
    begin
        sweep_result_t want;
        if (rst_n && in_valid && !in_stall)
            expected_sweeps.push_back(predict_sweep());
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_sweeps.size() == 0)
            begin
                $display("%0t: result with no request outstanding", $time);
                errors = errors + 1;
            end
            else
            begin
                want = expected_sweeps.pop_front();
                if (want.hit)
                    hits_seen = hits_seen + 1;
                if (hit !== want.hit)
                begin
                    $display("%0t: hit expected %0d got %0d", $time, want.hit, hit);
                    errors = errors + 1;
                end
                if (hit_time !== want.hit_time)
                begin
                    $display("%0t: hit_time expected %0d got %0d", $time,
                             want.hit_time, hit_time);
                    errors = errors + 1;
                end
                if (contact_x !== want.contact_x)
                begin
                    $display("%0t: contact_x expected %0d got %0d", $time,
                             want.contact_x, contact_x);
                    errors = errors + 1;
                end
                if (contact_y !== want.contact_y)
                begin
                    $display("%0t: contact_y expected %0d got %0d", $time,
                             want.contact_y, contact_y);
                    errors = errors + 1;
                end
                if (normal_x !== want.normal_x)
                begin
                    $display("%0t: normal_x expected %0d got %0d", $time,
                             want.normal_x, normal_x);
                    errors = errors + 1;
                end
                if (normal_y !== want.normal_y)
                begin
                    $display("%0t: normal_y expected %0d got %0d", $time,
                             want.normal_y, normal_y);
                    errors = errors + 1;
                end
            end
        end
        pending = expected_sweeps.size();
    end
endmodule
`default_nettype wire

>>> tb/sv/swept_box_slab_intersect_top_tb.sv
`default_nettype none
module swept_box_slab_intersect_top_tb;
    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] fixed_center_x;
    logic signed [31:0] fixed_center_y;
    logic [30:0]        fixed_width;
    logic [30:0]        fixed_height;
    logic signed [31:0] moving_center_x;
    logic signed [31:0] moving_center_y;
    logic [30:0]        moving_width;
    logic [30:0]        moving_height;
    logic signed [31:0] motion_x;
    logic signed [31:0] motion_y;
    logic               out_valid;
    logic               out_stall;
    logic               hit;
    logic [16:0]        hit_time;
    logic signed [31:0] contact_x;
    logic signed [31:0] contact_y;
    logic signed [1:0]  normal_x;
    logic signed [1:0]  normal_y;
    int                 errors;
    int                 pending;
    int                 hits_seen;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 requests_sent;

    localparam int S_MAX = 32'h7fffffff;
    localparam int S_MIN = 32'h80000000;
    localparam int W_MAX = 32'h7fffffff;
    localparam int ONE = 32'h00010000;

    swept_box_slab_intersect_top dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .fixed_center_x(fixed_center_x), .fixed_center_y(fixed_center_y),
        .fixed_width(fixed_width), .fixed_height(fixed_height),
        .moving_center_x(moving_center_x), .moving_center_y(moving_center_y),
        .moving_width(moving_width), .moving_height(moving_height),
        .motion_x(motion_x), .motion_y(motion_y),
        .out_valid(out_valid), .out_stall(out_stall), .hit(hit), .hit_time(hit_time),
        .contact_x(contact_x), .contact_y(contact_y),
        .normal_x(normal_x), .normal_y(normal_y)
    );

    swept_box_slab_intersect_checker checker_i (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .fixed_center_x(fixed_center_x), .fixed_center_y(fixed_center_y),
        .fixed_width(fixed_width), .fixed_height(fixed_height),
        .moving_center_x(moving_center_x), .moving_center_y(moving_center_y),
        .moving_width(moving_width), .moving_height(moving_height),
        .motion_x(motion_x), .motion_y(motion_y),
        .out_valid(out_valid), .out_stall(out_stall), .hit(hit), .hit_time(hit_time),
        .contact_x(contact_x), .contact_y(contact_y),
        .normal_x(normal_x), .normal_y(normal_y),
        .errors(errors), .pending(pending), .hits_seen(hits_seen)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(negedge clk)
        out_stall = ($urandom_range(99) < recv_idle_pct);

    initial
    begin
        #2000000;
        $display("[swept_box_slab_intersect_top] ERROR");
        $finish;
    end

    task automatic send_request(input int fcx, input int fcy, input int fw, input int fh,
                                input int mcx, input int mcy, input int mw, input int mh,
                                input int dx, input int dy);
        bit taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        fixed_center_x = fcx;
        fixed_center_y = fcy;
        fixed_width = 31'(fw);
        fixed_height = 31'(fh);
        moving_center_x = mcx;
        moving_center_y = mcy;
        moving_width = 31'(mw);
        moving_height = 31'(mh);
        motion_x = dx;
        motion_y = dy;
        in_valid = 1'b1;
        taken = 0;
        while (!taken)
        begin
            #1;
            taken = !in_stall;
            @(negedge clk);
        end
        requests_sent++;
    endtask

    task automatic send_random();
        int kind;
        int span;
        kind = $urandom_range(99);
        if (kind < 20)
            send_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom);
        else
        begin
            span = (kind < 90) ? 32'h00100000 : 32'h40000000;
            send_request($signed($urandom_range(span)) - span / 2,
                         $signed($urandom_range(span)) - span / 2,
                         $urandom_range(span / 2), $urandom_range(span / 2),
                         $signed($urandom_range(span)) - span / 2,
                         $signed($urandom_range(span)) - span / 2,
                         (kind % 7 == 0) ? 0 : $urandom_range(span / 4),
                         $urandom_range(span / 4),
                         (kind % 9 == 0) ? 0 : $signed($urandom_range(2 * span)) - span,
                         (kind % 11 == 0) ? 0 : $signed($urandom_range(2 * span)) - span);
        end
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        fixed_center_x = '0;
        fixed_center_y = '0;
        fixed_width = '0;
        fixed_height = '0;
        moving_center_x = '0;
        moving_center_y = '0;
        moving_width = '0;
        moving_height = '0;
        motion_x = '0;
        motion_y = '0;
        send_idle_pct = 21;
        recv_idle_pct = 83;
        requests_sent = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_request(0, 0, 2 * ONE, 2 * ONE, -4 * ONE, 0, ONE, ONE, 8 * ONE, 0);
        send_request(0, 0, 2 * ONE, 2 * ONE, 4 * ONE, 4 * ONE, ONE, ONE, -8 * ONE, -8 * ONE);
        send_request(0, 0, 2 * ONE, 2 * ONE, 0, 0, 0, 0, 0, 0);
        send_request(0, 0, 2 * ONE, 2 * ONE, 5 * ONE, 0, 0, 0, 0, 0);
        send_request(0, 0, 2 * ONE, 2 * ONE, 0, 0, 0, 0, 4 * ONE, ONE);
        send_request(0, 0, 2 * ONE, 2 * ONE, 0, 0, 6 * ONE, 6 * ONE, ONE, -ONE);
        send_request(0, 0, 2 * ONE, 2 * ONE, -4 * ONE, 4 * ONE, 0, 0, 8 * ONE, ONE);
        send_request(0, 0, 2 * ONE, 2 * ONE, 4 * ONE, 0, 0, 0, 8 * ONE, 0);
        send_request(0, 0, 2 * ONE, 2 * ONE, 2 * ONE, 0, 0, 0, 0, ONE);
        send_request(S_MAX, S_MAX, W_MAX, W_MAX, S_MIN, S_MIN, W_MAX, W_MAX, S_MAX, S_MAX);
        send_request(S_MIN, S_MIN, W_MAX, W_MAX, S_MAX, S_MAX, W_MAX, W_MAX, S_MIN, S_MIN);
        send_request(S_MIN, S_MAX, 0, 0, S_MAX, S_MIN, 0, 0, S_MIN, S_MAX);
        send_request(0, 0, W_MAX, W_MAX, 0, 0, 0, 0, S_MAX, S_MIN);
        send_request(0, 0, W_MAX, W_MAX, S_MAX, S_MIN, W_MAX, W_MAX, S_MIN, S_MAX);
        send_request(-1, -1, 1, 1, 0, 0, 1, 1, -1, 1);
        send_request(0, 0, 0, 0, -ONE, -ONE, 0, 0, 2 * ONE, 2 * ONE);
        send_request(S_MIN, 0, W_MAX, 0, S_MAX, 0, 0, W_MAX, S_MIN, 0);
        send_request(0, 0, 2 * ONE, 2 * ONE, -3 * ONE, -3 * ONE, 0, 0, ONE, ONE);
        send_request(0, 0, ONE, ONE, 0, 0, 0, 0, ONE, ONE);
        send_request(0, 0, 2 * ONE, 2 * ONE, -S_MAX, 0, 0, 0, S_MAX, 0);
        drain();
        repeat (230) send_random();

        send_idle_pct = 83;
        recv_idle_pct = 21;
        drain();
        repeat (230) send_random();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (230) send_random();

        drain();
        repeat (70) @(negedge clk);
        $display("Sent %0d requests under three idle mixes; %0d of the results were hits.",
                 requests_sent, hits_seen);
        if (errors == 0)
            $display("[swept_box_slab_intersect_top] OK");
        else
            $display("[swept_box_slab_intersect_top] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
